// ===== hdl/html_visible_text_extractor_core_assert.svh =====
// Assertion macros shared by the extractor RTL.
`ifndef HTML_VISIBLE_TEXT_EXTRACTOR_CORE_ASSERT_SVH
`define HTML_VISIBLE_TEXT_EXTRACTOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define HVTE_ASSERT_IMP(name, a, c) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("hvte assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define HVTE_ASSERT_NEXT(name, a, c) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("hvte assertion failed");

`endif

// ===== hdl/hvte_pkg.sv =====
// Types, constants and pattern tables of the HTML visible text extractor.
package hvte_pkg;

  localparam int COUNT_BITS = 16;
  localparam int CFG_W      = 16;
  localparam int CMP_W      = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

  // Queue depth must be a power of two (pointers wrap naturally).
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_LT = 8'h3C;
  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_SP = 8'h20;

  localparam logic [3:0] LEN_H1        = 4'd5;
  localparam logic [3:0] LEN_SCR_OPEN  = 4'd7;
  localparam logic [3:0] LEN_STY_OPEN  = 4'd6;
  localparam logic [3:0] LEN_SCR_CLOSE = 4'd9;
  localparam logic [3:0] LEN_STY_CLOSE = 4'd8;

  localparam logic CFG_IDX_MAX_LEN = 1'b0;

  typedef enum logic [1:0] {
    MODE_SEEK,
    MODE_TEXT,
    MODE_SKIP_SCRIPT,
    MODE_SKIP_STYLE
  } mode_t;

  typedef enum logic [2:0] {
    PAT_H1,
    PAT_SCR_OPEN,
    PAT_SCR_CLOSE,
    PAT_STY_OPEN,
    PAT_STY_CLOSE
  } pat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_lt;
    logic       is_gt;
    logic       is_ws;
  } beat_t;

  typedef struct packed {
    logic result;
    logic doc_clear;
  } back_stat_t;

  function automatic logic [3:0] pat_len(input pat_t p);
    logic [3:0] len;
    unique case (p)
      PAT_H1:        len = LEN_H1;
      PAT_SCR_OPEN:  len = LEN_SCR_OPEN;
      PAT_SCR_CLOSE: len = LEN_SCR_CLOSE;
      PAT_STY_OPEN:  len = LEN_STY_OPEN;
      PAT_STY_CLOSE: len = LEN_STY_CLOSE;
      default:       len = 4'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] pat_char(input pat_t p, input logic [3:0] pos);
    logic [7:0] c;
    c = 8'h00;
    unique case (p)
      PAT_H1: begin
        case (pos)
          4'd0: c = "<";
          4'd1: c = "/";
          4'd2: c = "h";
          4'd3: c = "1";
          4'd4: c = ">";
          default: c = 8'h00;
        endcase
      end
      PAT_SCR_OPEN: begin
        case (pos)
          4'd0: c = "<";
          4'd1: c = "s";
          4'd2: c = "c";
          4'd3: c = "r";
          4'd4: c = "i";
          4'd5: c = "p";
          4'd6: c = "t";
          default: c = 8'h00;
        endcase
      end
      PAT_SCR_CLOSE: begin
        case (pos)
          4'd0: c = "<";
          4'd1: c = "/";
          4'd2: c = "s";
          4'd3: c = "c";
          4'd4: c = "r";
          4'd5: c = "i";
          4'd6: c = "p";
          4'd7: c = "t";
          4'd8: c = ">";
          default: c = 8'h00;
        endcase
      end
      PAT_STY_OPEN: begin
        case (pos)
          4'd0: c = "<";
          4'd1: c = "s";
          4'd2: c = "t";
          4'd3: c = "y";
          4'd4: c = "l";
          4'd5: c = "e";
          default: c = 8'h00;
        endcase
      end
      PAT_STY_CLOSE: begin
        case (pos)
          4'd0: c = "<";
          4'd1: c = "/";
          4'd2: c = "s";
          4'd3: c = "t";
          4'd4: c = "y";
          4'd5: c = "l";
          4'd6: c = "e";
          4'd7: c = ">";
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // '<' only starts a pattern, so a mismatch restarts at 0 or 1.
  function automatic logic [3:0] match_step(input pat_t p, input logic [3:0] pos,
                                            input logic [7:0] b);
    logic [3:0] n;
    if (pos < pat_len(p) && b == pat_char(p, pos)) begin
      n = pos + 4'd1;
    end else begin
      n = (b == CH_LT) ? 4'd1 : 4'd0;
    end
    return n;
  endfunction

endpackage

// ===== hdl/hvte_front.sv =====
// Input side: accepts document beats, classifies each byte and queues it.
module hvte_front (
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,   // doc_byte
  input  logic          s_tlast,   // doc_last
  input  logic          full,
  output logic          push,
  output hvte_pkg::beat_t beat
);
  import hvte_pkg::*;

  assign s_tready = !full;
  assign push     = s_tvalid && !full;

  always_comb begin
    beat.data  = s_tdata;
    beat.last  = s_tlast;
    beat.is_lt = (s_tdata == CH_LT);
    beat.is_gt = (s_tdata == CH_GT);
    beat.is_ws = (s_tdata == CH_SP) || (s_tdata >= 8'h09 && s_tdata <= 8'h0D);
  end

endmodule

// ===== hdl/hvte_fifo.sv =====
// Short queue of classified beats between front and back.
module hvte_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  hvte_pkg::beat_t push_beat,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output hvte_pkg::beat_t head
);
  import hvte_pkg::*;

  beat_t                mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_CW-1:0]   count;

  assign full       = (count == FIFO_CW'(FIFO_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        2'b00,
        2'b11:   count <= count;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/hvte_back.sv =====
// Back end: scan state machine, text flags, length limit and result register.
module hvte_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      head_valid,
  input  hvte_pkg::beat_t           head,
  output logic                      pop,
  input  logic [hvte_pkg::CFG_W-1:0] max_text_len,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [7:0]                m_tdata,   // text_byte
  output logic                      m_tlast,   // text_end
  output logic                      m_tuser,   // byte_valid
  output hvte_pkg::back_stat_t      stat
);
  import hvte_pkg::*;

  mode_t                 mode, mode_next;
  logic [2:0]            h_pos, h_pos_next;
  logic [2:0]            scr_pos, scr_pos_next;
  logic [2:0]            sty_pos, sty_pos_next;
  logic [3:0]            cls_pos, cls_pos_next;
  logic                  copy, copy_next;
  logic                  prev_sp, prev_sp_next;
  logic                  sav_copy, sav_copy_next;
  logic                  sav_sp, sav_sp_next;
  logic [COUNT_BITS-1:0] count, count_next;

  logic [3:0] h_m, scr_m, sty_m, cls_m;
  pat_t       cls_pat;
  logic       room, copy_eff, emit, result;
  logic [7:0] ch;

  assign cls_pat = (mode == MODE_SKIP_SCRIPT) ? PAT_SCR_CLOSE : PAT_STY_CLOSE;
  assign h_m     = match_step(PAT_H1, {1'b0, h_pos}, head.data);
  assign scr_m   = match_step(PAT_SCR_OPEN, {1'b0, scr_pos}, head.data);
  assign sty_m   = match_step(PAT_STY_OPEN, {1'b0, sty_pos}, head.data);
  assign cls_m   = match_step(cls_pat, cls_pos, head.data);
  assign room    = (CMP_W'(count) < CMP_W'(max_text_len)) && (count != '1);
  assign copy_eff = copy && !head.is_lt;

  always_comb begin
    mode_next     = mode;
    h_pos_next    = h_pos;
    scr_pos_next  = scr_pos;
    sty_pos_next  = sty_pos;
    cls_pos_next  = cls_pos;
    copy_next     = copy;
    prev_sp_next  = prev_sp;
    sav_copy_next = sav_copy;
    sav_sp_next   = sav_sp;
    count_next    = count;
    emit          = 1'b0;
    ch            = 8'h00;
    unique case (mode)
      MODE_SEEK: begin
        if (h_m == LEN_H1) begin
          mode_next    = MODE_TEXT;
          h_pos_next   = '0;
          scr_pos_next = '0;
          sty_pos_next = '0;
          copy_next    = 1'b1;
          prev_sp_next = 1'b0;
        end else begin
          h_pos_next = h_m[2:0];
        end
      end
      MODE_TEXT: begin
        if (head.is_lt) begin
          sav_copy_next = copy;
          sav_sp_next   = prev_sp;
        end
        if (scr_m == LEN_SCR_OPEN || sty_m == LEN_STY_OPEN) begin
          mode_next    = (scr_m == LEN_SCR_OPEN) ? MODE_SKIP_SCRIPT : MODE_SKIP_STYLE;
          scr_pos_next = '0;
          sty_pos_next = '0;
          cls_pos_next = '0;
        end else begin
          scr_pos_next = scr_m[2:0];
          sty_pos_next = sty_m[2:0];
          if (head.is_ws) begin
            emit = copy_eff && !prev_sp && room;
            ch   = CH_SP;
          end else begin
            emit = copy_eff && room;
            ch   = head.data;
          end
          prev_sp_next = head.is_ws;
          copy_next    = head.is_gt ? 1'b1 : copy_eff;
          if (emit) begin
            count_next = count + 1'b1;
          end
        end
      end
      MODE_SKIP_SCRIPT,
      MODE_SKIP_STYLE: begin
        if (cls_m == pat_len(cls_pat)) begin
          mode_next    = MODE_TEXT;
          cls_pos_next = '0;
          copy_next    = sav_copy;
          prev_sp_next = sav_sp;
        end else begin
          cls_pos_next = cls_m;
        end
      end
      default: mode_next = mode;
    endcase
    if (head.last) begin
      mode_next     = MODE_SEEK;
      h_pos_next    = '0;
      scr_pos_next  = '0;
      sty_pos_next  = '0;
      cls_pos_next  = '0;
      copy_next     = 1'b1;
      prev_sp_next  = 1'b0;
      sav_copy_next = 1'b1;
      sav_sp_next   = 1'b0;
      count_next    = '0;
    end
  end

  assign result = emit || head.last;
  assign pop    = head_valid && (!result || !m_tvalid || m_tready);

  assign stat.result    = result;
  assign stat.doc_clear = (mode == MODE_SEEK) && (h_pos == '0) && (scr_pos == '0) &&
                          (sty_pos == '0) && (cls_pos == '0) && copy && !prev_sp &&
                          sav_copy && !sav_sp && (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_SEEK;
      h_pos    <= '0;
      scr_pos  <= '0;
      sty_pos  <= '0;
      cls_pos  <= '0;
      copy     <= 1'b1;
      prev_sp  <= 1'b0;
      sav_copy <= 1'b1;
      sav_sp   <= 1'b0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (pop) begin
        mode     <= mode_next;
        h_pos    <= h_pos_next;
        scr_pos  <= scr_pos_next;
        sty_pos  <= sty_pos_next;
        cls_pos  <= cls_pos_next;
        copy     <= copy_next;
        prev_sp  <= prev_sp_next;
        sav_copy <= sav_copy_next;
        sav_sp   <= sav_sp_next;
        count    <= count_next;
      end
      if (pop && result) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && result) begin
      m_tdata <= emit ? ch : 8'h00;
      m_tuser <= emit;
      m_tlast <= head.last;
    end
  end

endmodule

// ===== hdl/html_visible_text_extractor_core.sv =====
// Top level of the HTML visible text extractor. Takes one document byte per
// beat and, once the first "</h1>" has passed, returns the visible text:
// tags dropped, whitespace runs folded to one space, script and style
// elements skipped, at most max_text_len bytes per document. A result beat
// leaves for every emitted byte and for the document's last byte (tlast).
// The block accepts one byte per cycle while its queue is not full. A byte
// enters a 4-entry queue, the back end pops it from the queue head and
// registers its result in the output register as it pops, so a result beat
// is offered from that register and throughput is set only by m_tready.
`include "html_visible_text_extractor_core_assert.svh"

module html_visible_text_extractor_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // doc_byte
  input  logic        s_tlast,   // doc_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // text_byte
  output logic        m_tlast,   // text_end
  output logic        m_tuser,   // byte_valid
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hvte_pkg::*;

  logic             full, push, pop, head_valid;
  beat_t            push_beat, head;
  back_stat_t       stat;
  logic [CFG_W-1:0] max_text_len;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_IDX_MAX_LEN) ? {{(32-CFG_W){1'b0}}, max_text_len} : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_text_len <= '1;
    end else if (psel && penable && pwrite && pready && paddr[2] == CFG_IDX_MAX_LEN) begin
      max_text_len <= pwdata[CFG_W-1:0];
    end
  end

  hvte_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .full     (full),
    .push     (push),
    .beat     (push_beat)
  );

  hvte_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_beat  (push_beat),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  hvte_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .max_text_len (max_text_len),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .m_tuser      (m_tuser),
    .stat         (stat)
  );

  `HVTE_ASSERT_NEXT(a_push_lands, s_tvalid && s_tready && !pop, head_valid)
  `HVTE_ASSERT_NEXT(a_result_shown, pop && stat.result, m_tvalid)
  `HVTE_ASSERT_NEXT(a_last_clears, pop && head.last, stat.doc_clear)
  `HVTE_ASSERT_IMP(a_pop_has_item, pop, head_valid)

endmodule
